// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the tachometer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dwt_pkg.sv =====
package dwt_pkg;

  // Operation codes
  localparam logic [1:0] OpEdge  = 2'd0;
  localparam logic [1:0] OpQuery = 2'd1;
  localparam logic [1:0] OpArm   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CfgTargetSlots  = 2'd0;
  localparam logic [1:0] CfgCmPerSlot    = 2'd1;
  localparam logic [1:0] CfgSpeedFactor  = 2'd2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  // Field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned ArmW   = 16;
  localparam int unsigned RpmW   = 25;
  localparam int unsigned SpeedW = 19;
  localparam int unsigned CmW    = 16;
  localparam int unsigned SfW    = 24;
  localparam int unsigned DistW  = 48;

  // Register reset values
  localparam logic [ArmW-1:0] TargetReset = 16'd0;
  localparam logic [CmW-1:0]  CmReset     = 16'd269;
  localparam logic [SfW-1:0]  SfReset     = 24'd211884;

  // rpm numerator and speed saturation
  localparam logic [RpmW-1:0]   RpmNumerator = 25'd30000000;
  localparam logic [SpeedW-1:0] SpeedMax     = 19'd524287;

  // Divider runs one quotient bit per cycle over the numerator width
  localparam int unsigned BitCntW = 5;
  localparam logic [BitCntW-1:0] DivTopBit = 5'(RpmW - 1);

endpackage

// ===== rtl/core/dwt_in_if.sv =====
interface dwt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic       wheel;
  logic [dwt_pkg::TimeW-1:0] now_us;

  modport source (output valid, output operation, output wheel, output now_us,
                  input ready);
  modport sink (input valid, input operation, input wheel, input now_us,
                output ready);
endinterface

// ===== rtl/core/dwt_out_if.sv =====
interface dwt_out_if;
  logic valid;
  logic ready;
  logic [dwt_pkg::RpmW-1:0]   rpm;
  logic [dwt_pkg::SpeedW-1:0] speed_kmh;
  logic [dwt_pkg::CountW-1:0] slot_count;
  logic [dwt_pkg::DistW-1:0]  distance_cm_q8;
  logic measured;
  logic alert;

  modport source (output valid, output rpm, output speed_kmh, output slot_count,
                  output distance_cm_q8, output measured, output alert,
                  input ready);
  modport sink (input valid, input rpm, input speed_kmh, input slot_count,
                input distance_cm_q8, input measured, input alert,
                output ready);
endinterface

// ===== rtl/core/dual_wheel_encoder_tachometer.sv =====
// Each accepted word passes through setup, then, when a division runs, 25
// divider steps, then the speed and distance multiplies, before output.
// Words are handled one at a time; the next is taken only once the result
// is consumed, and the bit-serial rpm divider dominates the time per word.
// Reset (rst_ni low, asynchronous) clears all wheel state and restores the
// configuration registers to their defaults.
`include "assert_macros.svh"

module dual_wheel_encoder_tachometer (
  input  logic clk_i,
  input  logic rst_ni,
  dwt_in_if.sink    in_if,
  dwt_out_if.source out_if,
  input  logic                           cfg_we_i,
  input  logic [dwt_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [dwt_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  typedef enum logic [2:0] {
    StIdle, StSetup, StDiv, StMulSpd, StMulDist, StDone
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [dwt_pkg::ArmW-1:0] target_q;
  logic [dwt_pkg::CmW-1:0]  cm_q;
  logic [dwt_pkg::SfW-1:0]  sf_q;

  // Per-wheel state, index 0 left, 1 right
  logic [dwt_pkg::TimeW-1:0]  prev_q  [2];
  logic [dwt_pkg::TimeW-1:0]  last_q  [2];
  logic [dwt_pkg::CountW-1:0] total_q [2];
  logic [dwt_pkg::ArmW-1:0]   acnt_q  [2];
  logic [1:0] reached_q, seen_q;
  logic       armed_q;

  logic [dwt_pkg::TimeW-1:0]  prev_d  [2];
  logic [dwt_pkg::TimeW-1:0]  last_d  [2];
  logic [dwt_pkg::CountW-1:0] total_d [2];
  logic [dwt_pkg::ArmW-1:0]   acnt_d  [2];
  logic [1:0] reached_d, seen_d;
  logic       armed_d, alert_d;
  logic [dwt_pkg::ArmW-1:0]   acnt_inc;

  // Item and datapath registers
  logic                        wheel_q;
  logic [dwt_pkg::TimeW-1:0]   now_q;
  logic                        alert_q;
  logic                        meas_q;
  logic [dwt_pkg::TimeW-1:0]   period_q;
  logic [dwt_pkg::TimeW-1:0]   rem_q;
  logic [dwt_pkg::RpmW-1:0]    rpm_q;
  logic [dwt_pkg::BitCntW-1:0] bit_cnt_q;
  logic [dwt_pkg::SpeedW-1:0]  speed_q;
  logic [dwt_pkg::CountW-1:0]  slot_q;
  logic [dwt_pkg::DistW-1:0]   dist_q;

  logic in_acc, out_acc;
  assign in_acc  = in_if.valid && in_if.ready;
  assign out_acc = out_if.valid && out_if.ready;

  // Next wheel state for the accepted word, alert check after the update
  assign acnt_inc = acnt_q[in_if.wheel] + dwt_pkg::ArmW'(1);

  always_comb begin
    prev_d    = prev_q;
    last_d    = last_q;
    total_d   = total_q;
    acnt_d    = acnt_q;
    reached_d = reached_q;
    seen_d    = seen_q;
    armed_d   = armed_q;
    case (in_if.operation)
      dwt_pkg::OpEdge: begin
        prev_d[in_if.wheel]  = last_q[in_if.wheel];
        last_d[in_if.wheel]  = in_if.now_us;
        total_d[in_if.wheel] = total_q[in_if.wheel] + dwt_pkg::CountW'(1);
        seen_d[in_if.wheel]  = 1'b1;
        if (armed_q && !reached_q[in_if.wheel]) begin
          acnt_d[in_if.wheel] = acnt_inc;
          if (acnt_inc == target_q) begin
            reached_d[in_if.wheel] = 1'b1;
          end
        end
      end
      dwt_pkg::OpArm: begin
        acnt_d[0] = '0;
        acnt_d[1] = '0;
        reached_d = '0;
        armed_d   = 1'b1;
      end
      default: begin
      end
    endcase
    alert_d = armed_d && reached_d[0] && reached_d[1];
    if (alert_d) begin
      armed_d = 1'b0;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= dwt_pkg::TargetReset;
      cm_q     <= dwt_pkg::CmReset;
      sf_q     <= dwt_pkg::SfReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dwt_pkg::CfgTargetSlots: target_q <= cfg_wdata_i[dwt_pkg::ArmW-1:0];
        dwt_pkg::CfgCmPerSlot:   cm_q     <= cfg_wdata_i[dwt_pkg::CmW-1:0];
        dwt_pkg::CfgSpeedFactor: sf_q     <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Wheel state update on acceptance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '{default: '0};
      last_q    <= '{default: '0};
      total_q   <= '{default: '0};
      acnt_q    <= '{default: '0};
      reached_q <= '0;
      seen_q    <= '0;
      armed_q   <= 1'b0;
    end else if (in_acc) begin
      prev_q    <= prev_d;
      last_q    <= last_d;
      total_q   <= total_d;
      acnt_q    <= acnt_d;
      reached_q <= reached_d;
      seen_q    <= seen_d;
      armed_q   <= armed_d;
    end
  end

  // Setup: period is the larger of the last edge gap and the time since it
  logic [dwt_pkg::TimeW-1:0] gap, since, period;
  assign gap    = last_q[wheel_q] - prev_q[wheel_q];
  assign since  = now_q - last_q[wheel_q];
  assign period = (since > gap) ? since : gap;

  // Divider step: shift in one numerator bit, trial subtract
  logic [dwt_pkg::TimeW:0]   rem_shift;
  logic                      div_ge;
  logic [dwt_pkg::TimeW:0]   rem_sub;
  assign rem_shift = {rem_q, dwt_pkg::RpmNumerator[bit_cnt_q]};
  assign div_ge    = rem_shift >= {1'b0, period_q};
  assign rem_sub   = rem_shift - {1'b0, period_q};

  // Shared multiplier: speed first, then distance
  logic [dwt_pkg::TimeW-1:0]          mul_a;
  logic [dwt_pkg::SfW-1:0]            mul_b;
  logic [dwt_pkg::TimeW+dwt_pkg::SfW-1:0] mul_p;
  logic [dwt_pkg::TimeW-1:0]          speed_raw;

  always_comb begin
    if (state_q == StMulDist) begin
      mul_a = slot_q;
      mul_b = dwt_pkg::SfW'(cm_q);
    end else begin
      mul_a = dwt_pkg::TimeW'(rpm_q);
      mul_b = sf_q;
    end
  end
  assign mul_p     = mul_a * mul_b;
  assign speed_raw = mul_p[dwt_pkg::TimeW+dwt_pkg::SfW-1:dwt_pkg::SfW];

  // Sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      wheel_q   <= 1'b0;
      now_q     <= '0;
      alert_q   <= 1'b0;
      meas_q    <= 1'b0;
      period_q  <= '0;
      rem_q     <= '0;
      rpm_q     <= '0;
      bit_cnt_q <= '0;
      speed_q   <= '0;
      slot_q    <= '0;
      dist_q    <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            state_q <= StSetup;
            wheel_q <= in_if.wheel;
            now_q   <= in_if.now_us;
            alert_q <= alert_d;
          end
        end
        StSetup: begin
          period_q  <= period;
          meas_q    <= seen_q[wheel_q];
          slot_q    <= total_q[wheel_q];
          rem_q     <= '0;
          bit_cnt_q <= dwt_pkg::DivTopBit;
          if (!seen_q[wheel_q])   rpm_q <= '0;
          else if (period == '0)  rpm_q <= dwt_pkg::RpmNumerator;
          else                    rpm_q <= '0;
          if (seen_q[wheel_q] && period != '0) state_q <= StDiv;
          else                                 state_q <= StMulSpd;
        end
        StDiv: begin
          rem_q     <= div_ge ? rem_sub[dwt_pkg::TimeW-1:0] : rem_shift[dwt_pkg::TimeW-1:0];
          rpm_q     <= {rpm_q[dwt_pkg::RpmW-2:0], div_ge};
          bit_cnt_q <= bit_cnt_q - dwt_pkg::BitCntW'(1);
          if (bit_cnt_q == '0) state_q <= StMulSpd;
        end
        StMulSpd: begin
          if (speed_raw > dwt_pkg::TimeW'(dwt_pkg::SpeedMax)) speed_q <= dwt_pkg::SpeedMax;
          else speed_q <= speed_raw[dwt_pkg::SpeedW-1:0];
          state_q <= StMulDist;
        end
        StMulDist: begin
          dist_q  <= mul_p[dwt_pkg::DistW-1:0];
          state_q <= StDone;
        end
        StDone: begin
          if (out_acc) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Channel outputs
  assign in_if.ready           = (state_q == StIdle);
  assign out_if.valid          = (state_q == StDone);
  assign out_if.rpm            = rpm_q;
  assign out_if.speed_kmh      = speed_q;
  assign out_if.slot_count     = slot_q;
  assign out_if.distance_cm_q8 = dist_q;
  assign out_if.measured       = meas_q;
  assign out_if.alert          = alert_q;

  // Checks
  `ASSERT_IMPL(a_ready_excl_valid, clk_i, rst_ni, in_if.ready, !out_if.valid,
    "input ready while a result is pending")
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, !in_if.ready,
    "block took a second word while busy")
  `ASSERT_IMPL(a_alert_disarms, clk_i, rst_ni, out_if.valid && out_if.alert, !armed_q,
    "alert reported while still armed")
  `ASSERT_IMPL(a_unmeasured_zero, clk_i, rst_ni, out_if.valid && !out_if.measured,
    out_if.rpm == '0 && out_if.speed_kmh == '0, "rpm nonzero for an unmeasured wheel")

endmodule

// ===== bench/tach_reading_checker.sv =====
`timescale 1ns / 1ps

module tach_reading_checker
  import dwt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  dwt_in_if                   in_mon,
  dwt_out_if                  out_mon,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int unsigned         mismatches_o,
  output int unsigned         readings_pending_o
);

  typedef struct {
    logic [RpmW-1:0]   rpm;
    logic [SpeedW-1:0] speed_kmh;
    logic [CountW-1:0] slot_count;
    logic [DistW-1:0]  distance_cm_q8;
    logic              measured;
    logic              alert;
  } tach_reading_t;

  // shadow registers
  logic [ArmW-1:0] target_q;
  logic [CmW-1:0]  cm_per_slot_q;
  logic [SfW-1:0]  speed_factor_q;

  // per-wheel state, indexed by the wheel bit
  logic [TimeW-1:0]  prev_edge_t [2];
  logic [TimeW-1:0]  last_edge_t [2];
  logic [CountW-1:0] slots_total [2];
  logic [ArmW-1:0]   armed_slots [2];
  logic              hit_target  [2];
  logic              seen_edge   [2];
  logic              armed;

  tach_reading_t readings_due[$];
  tach_reading_t want;

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, field, got, exp_val);
    mismatches_o++;
  endtask

  // Apply one word to the wheel state, then read out the selected wheel
  function automatic tach_reading_t predict_reading(input logic [1:0] op, input logic w,
                                                    input logic [TimeW-1:0] now_us);
    tach_reading_t r;
    logic [TimeW-1:0] span;
    logic [TimeW-1:0] since;
    logic [63:0]      prod;
    if (op == OpEdge) begin
      prev_edge_t[w] = last_edge_t[w];
      last_edge_t[w] = now_us;
      slots_total[w] = slots_total[w] + 1'b1;
      seen_edge[w]   = 1'b1;
      if (armed && !hit_target[w]) begin
        armed_slots[w] = armed_slots[w] + 1'b1;
        if (armed_slots[w] == target_q) hit_target[w] = 1'b1;
      end
    end else if (op == OpArm) begin
      armed_slots[0] = '0;
      armed_slots[1] = '0;
      hit_target[0]  = 1'b0;
      hit_target[1]  = 1'b0;
      armed          = 1'b1;
    end

    // both wheels done while armed: one-shot alert
    r.alert = 1'b0;
    if (armed && hit_target[0] && hit_target[1]) begin
      r.alert = 1'b1;
      armed   = 1'b0;
    end

    r.rpm       = '0;
    r.speed_kmh = '0;
    if (seen_edge[w]) begin
      span  = last_edge_t[w] - prev_edge_t[w];
      since = now_us - last_edge_t[w];
      if (since > span) span = since;
      if (span == '0) r.rpm = RpmNumerator;
      else r.rpm = RpmW'(TimeW'(RpmNumerator) / span);
      prod = (64'(r.rpm) * 64'(speed_factor_q)) >> 24;
      r.speed_kmh = (prod > 64'(SpeedMax)) ? SpeedMax : prod[SpeedW-1:0];
    end
    r.slot_count     = slots_total[w];
    r.distance_cm_q8 = DistW'(slots_total[w]) * DistW'(cm_per_slot_q);
    r.measured       = seen_edge[w];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q       = TargetReset;
      cm_per_slot_q  = CmReset;
      speed_factor_q = SfReset;
      for (int i = 0; i < 2; i++) begin
        prev_edge_t[i] = '0;
        last_edge_t[i] = '0;
        slots_total[i] = '0;
        armed_slots[i] = '0;
        hit_target[i]  = 1'b0;
        seen_edge[i]   = 1'b0;
      end
      armed = 1'b0;
      readings_due.delete();
      mismatches_o       = 0;
      readings_pending_o = 0;
    end else begin
      // results first: a word never leaves on the edge its input is taken
      if (out_mon.valid && out_mon.ready) begin
        if (readings_due.size() == 0) begin
          report_mismatch("unexpected word", 64'(out_mon.rpm), 64'd0);
        end else begin
          want = readings_due.pop_front();
          if (out_mon.rpm !== want.rpm)
            report_mismatch("rpm", 64'(out_mon.rpm), 64'(want.rpm));
          if (out_mon.speed_kmh !== want.speed_kmh)
            report_mismatch("speed_kmh", 64'(out_mon.speed_kmh), 64'(want.speed_kmh));
          if (out_mon.slot_count !== want.slot_count)
            report_mismatch("slot_count", 64'(out_mon.slot_count), 64'(want.slot_count));
          if (out_mon.distance_cm_q8 !== want.distance_cm_q8)
            report_mismatch("distance_cm_q8", 64'(out_mon.distance_cm_q8),
                            64'(want.distance_cm_q8));
          if (out_mon.measured !== want.measured)
            report_mismatch("measured", 64'(out_mon.measured), 64'(want.measured));
          if (out_mon.alert !== want.alert)
            report_mismatch("alert", 64'(out_mon.alert), 64'(want.alert));
        end
      end

      if (in_mon.valid && in_mon.ready)
        readings_due.push_back(predict_reading(in_mon.operation, in_mon.wheel,
                                               in_mon.now_us));

      // register writes must land only while the block is idle; the block does not enforce it
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgTargetSlots: target_q       = cfg_wdata_i[ArmW-1:0];
          CfgCmPerSlot:   cm_per_slot_q  = cfg_wdata_i[CmW-1:0];
          CfgSpeedFactor: speed_factor_q = cfg_wdata_i[SfW-1:0];
          default: ;
        endcase
      end

      readings_pending_o = $unsigned(readings_due.size());
    end
  end

endmodule

// ===== bench/dual_wheel_encoder_tachometer_tb.sv =====
`timescale 1ns / 1ps

module dual_wheel_encoder_tachometer_tb;
  import dwt_pkg::*;

  // undefined op code, behaves as a query
  localparam logic [1:0] OpQueryAlt = 2'd3;
  localparam logic       WheelLeft  = 1'b0;
  localparam logic       WheelRight = 1'b1;

  localparam int unsigned PhaseWords   = 75;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned RxHoldCycles = 200;
  localparam int unsigned StallLimit   = 3000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;
  int unsigned         mismatches;
  int unsigned         readings_pending;

  int unsigned      tx_idle_pct;
  int unsigned      rx_idle_pct;
  bit               hold_req;
  logic [TimeW-1:0] clock_us;
  int unsigned      stall_cycles;

  dwt_in_if  in_ch ();
  dwt_out_if out_ch ();

  dual_wheel_encoder_tachometer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  tach_reading_checker reading_chk (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_mon             (in_ch),
    .out_mon            (out_ch),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_wdata_i        (cfg_wdata),
    .mismatches_o       (mismatches),
    .readings_pending_o (readings_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Offer one word, with random idle cycles ahead of it
  task automatic send_word(input logic [1:0] op, input logic w, input logic [TimeW-1:0] t_us);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.wheel     <= w;
    in_ch.now_us    <= t_us;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Mostly a plausible edge/query/arm stream on a running clock, some noise
  task automatic send_random_word();
    int unsigned pick;
    logic [1:0]  op;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      send_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 84) clock_us += $urandom_range(1, 4000);
      else if (pick < 91) clock_us += $urandom_range(4001, 5000000);
      else if (pick < 94) clock_us = $urandom;
      // else same microsecond again: no time since the last word
      pick = $urandom_range(0, 99);
      if (pick < 62) op = OpEdge;
      else if (pick < 88) op = OpQuery;
      else if (pick < 96) op = OpArm;
      else op = OpQueryAlt;
      send_word(op, 1'($urandom_range(0, 1)), clock_us);
    end
  endtask

  // Stop offering and wait for every result, plus pipeline settle
  task automatic drain_readings();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (readings_pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [ArmW-1:0] tgt, input logic [CmW-1:0] cm,
                               input logic [SfW-1:0] sf);
    cfg_we    <= 1'b1;
    cfg_index <= CfgTargetSlots;
    cfg_wdata <= CfgDataW'(tgt);
    @(posedge clk_i);
    cfg_index <= CfgCmPerSlot;
    cfg_wdata <= CfgDataW'(cm);
    @(posedge clk_i);
    cfg_index <= CfgSpeedFactor;
    cfg_wdata <= CfgDataW'(sf);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result side: random backpressure, one long hold on request
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CfgTargetSlots;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OpQuery;
    in_ch.wheel     = WheelLeft;
    in_ch.now_us    = '0;
    tx_idle_pct     = 25;
    rx_idle_pct     = 25;
    hold_req        = 1'b0;
    clock_us        = $urandom;
    stall_cycles    = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: small target so the alert fires quickly
    load_settings(16'd2, CmReset, SfReset);
    send_word(OpQuery, WheelLeft, 32'd0);              // no edge yet
    send_word(OpQuery, WheelRight, 32'hFFFF_FFFF);
    send_word(OpQueryAlt, WheelLeft, 32'd12345);
    send_word(OpEdge, WheelLeft, 32'd1000);
    send_word(OpQuery, WheelLeft, 32'd1500);
    send_word(OpEdge, WheelLeft, 32'd1000);            // zero period, rpm saturates
    send_word(OpEdge, WheelRight, 32'hFFFF_FFF0);
    send_word(OpEdge, WheelRight, 32'h0000_0010);      // time wraps between edges
    send_word(OpQuery, WheelRight, 32'h0000_0030);
    send_word(OpArm, WheelLeft, 32'h0000_0040);
    send_word(OpEdge, WheelLeft, 32'h0000_0100);
    send_word(OpEdge, WheelLeft, 32'h0000_0200);       // left reaches target
    send_word(OpEdge, WheelLeft, 32'h0000_0300);       // not counted once reached
    send_word(OpEdge, WheelRight, 32'h0000_0400);
    send_word(OpEdge, WheelRight, 32'h0000_0500);      // both reached: alert
    send_word(OpQuery, WheelRight, 32'h0000_0600);
    send_word(OpEdge, WheelLeft, 32'h0000_0700);       // disarmed, no count
    send_word(OpArm, WheelRight, 32'h0000_0800);
    send_word(OpQuery, WheelLeft, 32'h0000_0000);
    send_word(OpEdge, WheelLeft, 32'hFFFF_FFFF);
    send_word(OpQuery, WheelLeft, 32'h0000_0000);

    // random phases under several register settings
    for (int ph = 0; ph < 6; ph++) begin
      drain_readings();
      case (ph)
        0: load_settings(16'd1, 16'hFFFF, 24'hFF_FFFF);
        1: load_settings(16'hFFFF, 16'd0, 24'd0);
        2: load_settings(16'd0, 16'($urandom_range(0, 16'hFFFF)),
                         24'($urandom_range(0, 24'hFF_FFFF)));
        default: load_settings(16'($urandom_range(1, 5)), 16'($urandom_range(0, 16'hFFFF)),
                               24'($urandom_range(0, 24'hFF_FFFF)));
      endcase
      // one phase runs without any idling
      tx_idle_pct = (ph == 2) ? 0 : 25;
      rx_idle_pct = (ph == 2) ? 0 : 25;
      if (ph == 0) hold_req = 1'b1;
      repeat (PhaseWords) send_random_word();
    end

    drain_readings();
    if (mismatches == 0 && readings_pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== dual_wheel_encoder_tachometer.f =====
+incdir+rtl/core
rtl/core/dwt_pkg.sv
rtl/core/dwt_in_if.sv
rtl/core/dwt_out_if.sv
rtl/core/dual_wheel_encoder_tachometer.sv
bench/tach_reading_checker.sv
bench/dual_wheel_encoder_tachometer_tb.sv
